/* rtl/gcdw_pkg.sv */
// Shared types, constants and arithmetic helpers of the great-circle distance block.
`default_nettype none
package gcdw_pkg;

	localparam int TRIG_FRACTION_BITS = 30;
	localparam int DISTANCE_DIVISOR = 10000;
	localparam int CORDIC_STEPS = 32;

	// Trigonometric values carry a few integer bits above Q2.F for CORDIC growth.
	localparam int TW = TRIG_FRACTION_BITS + 6;
	localparam int AW = 34;

	localparam int LAT_W = 24;
	localparam int LON_W = 25;
	localparam int IN_FIELDS_W = 2 * LAT_W + 2 * LON_W;
	localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int WEIGHT_W = 13;
	localparam int OUT_TDATA_W = ((WEIGHT_W + 7) / 8) * 8;
	localparam int RADIUS_W = 24;

	typedef logic signed [TW-1:0] trig_t;
	typedef logic signed [AW-1:0] ang_t;

	localparam logic [RADIUS_W-1:0] RADIUS_DEFAULT = 24'd6372795;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};
	localparam ang_t QUARTER_TURN = ang_t'(64'd1 << 30);
	localparam ang_t HALF_TURN = ang_t'(64'd1 << 31);

	localparam logic [63:0] GAIN_RAW = 64'h9B74EDA8;
	localparam int GAIN_UP = (TRIG_FRACTION_BITS >= 32) ? TRIG_FRACTION_BITS - 32 : 0;
	localparam int GAIN_DN = (TRIG_FRACTION_BITS >= 32) ? 0 : 32 - TRIG_FRACTION_BITS;
	localparam trig_t GAIN_Q = trig_t'((GAIN_RAW << GAIN_UP) >> GAIN_DN);

	// Reciprocal of 45 scaled by 2^32, rounded up; exact for operands below 2^26.
	localparam logic [26:0] RECIP45 = 27'(((64'd1 << 32) + 64'd44) / 64'd45);
	localparam int DIV_SHIFT = 48;
	localparam logic [48:0] DIV_RECIP =
		49'(((64'd1 << DIV_SHIFT) + 64'(DISTANCE_DIVISOR) - 64'd1) / 64'(DISTANCE_DIVISOR));

	// 2*pi in Q61, split into halves for the partial products.
	localparam logic [31:0] TWO_PI_HI = 32'hC90FDAA2;
	localparam logic [31:0] TWO_PI_LO = 32'h2168C234;

	localparam ang_t ATAN_STEPS [0:CORDIC_STEPS-1] = '{
		ang_t'(536870912), ang_t'(316933406), ang_t'(167458907), ang_t'(85004756),
		ang_t'(42667331), ang_t'(21354465), ang_t'(10679838), ang_t'(5340245),
		ang_t'(2670163), ang_t'(1335087), ang_t'(667544), ang_t'(333772),
		ang_t'(166886), ang_t'(83443), ang_t'(41722), ang_t'(20861),
		ang_t'(10430), ang_t'(5215), ang_t'(2608), ang_t'(1304),
		ang_t'(652), ang_t'(326), ang_t'(163), ang_t'(81),
		ang_t'(41), ang_t'(20), ang_t'(10), ang_t'(5),
		ang_t'(3), ang_t'(1), ang_t'(1), ang_t'(0)
	};

	// Fixed-point product, truncated toward zero back to Q(F).
	function automatic trig_t mulq(input trig_t a, input trig_t b);
		logic [TW-1:0] ua;
		logic [TW-1:0] ub;
		logic [2*TW-1:0] pr;
		logic [TW-1:0] r;
		logic neg;
		ua = a[TW-1] ? $unsigned(-a) : $unsigned(a);
		ub = b[TW-1] ? $unsigned(-b) : $unsigned(b);
		neg = a[TW-1] ^ b[TW-1];
		pr = ua * ub;
		r = pr[TRIG_FRACTION_BITS +: TW];
		return neg ? -$signed(r) : $signed(r);
	endfunction

	function automatic trig_t abs_t(input trig_t a);
		return a[TW-1] ? -a : a;
	endfunction

endpackage
`default_nettype wire

/* rtl/great_circle_distance_weight.sv */
// Top level: pipelined great-circle distance weight between two points.
`default_nettype none
// The block takes one coordinate pair per cycle while the output is not held and returns one
// weight per pair. Its pipeline is three 32-step CORDIC chains in sequence (sine and cosine of
// both latitudes and of the longitude difference, then two vectoring passes for the root and
// the arc tangent), each step one register stage, plus degree conversion, the product stages
// and the split multiply of the final scaling. When a result is held at the output, the
// whole pipeline holds with it. The radius is read by the scaling stage, so it must only be
// written while no request is in flight.
module great_circle_distance_weight (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// first_latitude, first_longitude, second_latitude, second_longitude, zero pad
	input  wire logic [gcdw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// distance_weight, zero pad
	output logic [gcdw_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [gcdw_pkg::RADIUS_W-1:0]    cfg_data
);
	import gcdw_pkg::*;

	localparam int N = CORDIC_STEPS;

	logic adv;
	logic [RADIUS_W-1:0] radius_q;
	logic out_valid_q;
	logic [WEIGHT_W-1:0] weight_q;

	assign adv = ~out_valid_q | m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = OUT_TDATA_W'(weight_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_DEFAULT;
		end else if (cfg_valid) begin
			radius_q <= cfg_data;
		end
	end

	// Degree to binary angle conversion for lat1, lat2 and the longitude difference.
	logic v_s1, v_s2, v_s3, v_s4;
	logic [25:0] u_s1 [0:2];
	logic [25:0] u_s2 [0:2];
	logic neg_s1 [0:2];
	logic neg_s2 [0:2];
	logic neg_s3 [0:2];
	logic [20:0] q1_s2 [0:2];
	logic [20:0] q1_s3 [0:2];
	logic [5:0] r_s3 [0:2];
	logic [31:0] ba_s4 [0:2];

	logic signed [25:0] ain [0:2];
	always_comb begin
		ain[0] = 26'(signed'(s_axis_tdata[LAT_W-1:0]));
		ain[1] = 26'(signed'(s_axis_tdata[LAT_W+LON_W +: LAT_W]));
		ain[2] = 26'(signed'(s_axis_tdata[2*LAT_W+LON_W +: LON_W]))
			- 26'(signed'(s_axis_tdata[LAT_W +: LON_W]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic [52:0] p1;
		logic [25:0] rf;
		logic [18:0] v2;
		logic [45:0] p2;
		logic [33:0] ba;
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				neg_s1[k] <= ain[k][25];
				u_s1[k] <= ain[k][25] ? $unsigned(-ain[k]) : $unsigned(ain[k]);
				p1 = 53'(u_s1[k]) * 53'(RECIP45);
				q1_s2[k] <= p1[52:32];
				u_s2[k] <= u_s1[k];
				neg_s2[k] <= neg_s1[k];
				rf = u_s2[k] - 26'(q1_s2[k]) * 26'd45;
				r_s3[k] <= rf[5:0];
				q1_s3[k] <= q1_s2[k];
				neg_s3[k] <= neg_s2[k];
				// Remainder part of round(u * 65536 / 360) as floor((r * 8192 + 22) / 45).
				v2 = {r_s3[k], 13'd0} + 19'd22;
				p2 = 46'(v2) * 46'(RECIP45);
				ba = {q1_s3[k], 13'd0} + 34'(p2[45:32]);
				ba_s4[k] <= neg_s3[k] ? 32'(-ba) : ba[31:0];
			end
		end
	end

	// Rotation CORDIC, index 0 is the folded start.
	trig_t rx_s [0:N][0:2];
	trig_t ry_s [0:N][0:2];
	ang_t rz_s [0:N][0:2];
	logic rflip_s [0:N][0:2];
	logic rv_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s[0] <= 1'b0;
		end else if (adv) begin
			rv_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ang_t z;
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				z = ang_t'(signed'(ba_s4[k]));
				rx_s[0][k] <= GAIN_Q;
				ry_s[0][k] <= '0;
				if (z > QUARTER_TURN) begin
					rz_s[0][k] <= z - HALF_TURN;
					rflip_s[0][k] <= 1'b1;
				end else if (z < -QUARTER_TURN) begin
					rz_s[0][k] <= z + HALF_TURN;
					rflip_s[0][k] <= 1'b1;
				end else begin
					rz_s[0][k] <= z;
					rflip_s[0][k] <= 1'b0;
				end
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s[i+1] <= 1'b0;
			end else if (adv) begin
				rv_s[i+1] <= rv_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int k = 0; k < 3; k++) begin
					rflip_s[i+1][k] <= rflip_s[i][k];
					if (!rz_s[i][k][AW-1]) begin
						rx_s[i+1][k] <= rx_s[i][k] - (ry_s[i][k] >>> i);
						ry_s[i+1][k] <= ry_s[i][k] + (rx_s[i][k] >>> i);
						rz_s[i+1][k] <= rz_s[i][k] - ATAN_STEPS[i];
					end else begin
						rx_s[i+1][k] <= rx_s[i][k] + (ry_s[i][k] >>> i);
						ry_s[i+1][k] <= ry_s[i][k] - (rx_s[i][k] >>> i);
						rz_s[i+1][k] <= rz_s[i][k] + ATAN_STEPS[i];
					end
				end
			end
		end
	end

	trig_t s1, c1, s2, c2, sd, cd;
	assign c1 = rflip_s[N][0] ? -rx_s[N][0] : rx_s[N][0];
	assign s1 = rflip_s[N][0] ? -ry_s[N][0] : ry_s[N][0];
	assign c2 = rflip_s[N][1] ? -rx_s[N][1] : rx_s[N][1];
	assign s2 = rflip_s[N][1] ? -ry_s[N][1] : ry_s[N][1];
	assign cd = rflip_s[N][2] ? -rx_s[N][2] : rx_s[N][2];
	assign sd = rflip_s[N][2] ? -ry_s[N][2] : ry_s[N][2];

	// Products of the Vincenty terms.
	logic vm_s1, vm_s2;
	trig_t t_m1, ya_m1, c1s2_m1, s1s2_m1, s1_m1, c1_m1;
	trig_t ya_m2, c1s2_m2, s1s2_m2, s1t_m2, c1t_m2;

	// Vectoring CORDIC for the root of the sum of squares.
	trig_t w1x_s [0:N];
	trig_t w1y_s [0:N];
	trig_t w1xv_s [0:N];
	logic w1v_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vm_s1 <= 1'b0;
			vm_s2 <= 1'b0;
			w1v_s[0] <= 1'b0;
		end else if (adv) begin
			vm_s1 <= rv_s[N];
			vm_s2 <= vm_s1;
			w1v_s[0] <= vm_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_m1 <= mulq(c2, cd);
			ya_m1 <= mulq(c2, sd);
			c1s2_m1 <= mulq(c1, s2);
			s1s2_m1 <= mulq(s1, s2);
			s1_m1 <= s1;
			c1_m1 <= c1;
			s1t_m2 <= mulq(s1_m1, t_m1);
			c1t_m2 <= mulq(c1_m1, t_m1);
			ya_m2 <= ya_m1;
			c1s2_m2 <= c1s2_m1;
			s1s2_m2 <= s1s2_m1;
			w1x_s[0] <= abs_t(ya_m2);
			w1y_s[0] <= abs_t(c1s2_m2 - s1t_m2);
			w1xv_s[0] <= s1s2_m2 + c1t_m2;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec1
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				w1v_s[i+1] <= 1'b0;
			end else if (adv) begin
				w1v_s[i+1] <= w1v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				w1xv_s[i+1] <= w1xv_s[i];
				if (!w1y_s[i][TW-1]) begin
					w1x_s[i+1] <= w1x_s[i] + (w1y_s[i] >>> i);
					w1y_s[i+1] <= w1y_s[i] - (w1x_s[i] >>> i);
				end else begin
					w1x_s[i+1] <= w1x_s[i] - (w1y_s[i] >>> i);
					w1y_s[i+1] <= w1y_s[i] + (w1x_s[i] >>> i);
				end
			end
		end
	end

	// Gain correction of the magnitude, then the quarter-turn pre-rotation.
	logic vg_s1;
	trig_t mag_g1, xv_g1;
	trig_t w2x_s [0:N];
	trig_t w2y_s [0:N];
	ang_t w2z_s [0:N];
	logic w2v_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vg_s1 <= 1'b0;
			w2v_s[0] <= 1'b0;
		end else if (adv) begin
			vg_s1 <= w1v_s[N];
			w2v_s[0] <= vg_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_g1 <= mulq(w1x_s[N], GAIN_Q);
			xv_g1 <= w1xv_s[N];
			if (!xv_g1[TW-1]) begin
				w2x_s[0] <= xv_g1;
				w2y_s[0] <= mag_g1;
				w2z_s[0] <= '0;
			end else if (!mag_g1[TW-1]) begin
				w2x_s[0] <= mag_g1;
				w2y_s[0] <= -xv_g1;
				w2z_s[0] <= QUARTER_TURN;
			end else begin
				w2x_s[0] <= -mag_g1;
				w2y_s[0] <= xv_g1;
				w2z_s[0] <= -QUARTER_TURN;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec2
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				w2v_s[i+1] <= 1'b0;
			end else if (adv) begin
				w2v_s[i+1] <= w2v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!w2y_s[i][TW-1]) begin
					w2x_s[i+1] <= w2x_s[i] + (w2y_s[i] >>> i);
					w2y_s[i+1] <= w2y_s[i] - (w2x_s[i] >>> i);
					w2z_s[i+1] <= w2z_s[i] + ATAN_STEPS[i];
				end else begin
					w2x_s[i+1] <= w2x_s[i] - (w2y_s[i] >>> i);
					w2y_s[i+1] <= w2y_s[i] + (w2x_s[i] >>> i);
					w2z_s[i+1] <= w2z_s[i] - ATAN_STEPS[i];
				end
			end
		end
	end

	// Scaling: angle * radius * 2pi / 2^32, then division by a constant.
	logic vp_s1, vp_s2, vp_s3, vp_s4;
	ang_t ang_c;
	logic [31:0] ang_u;
	logic [55:0] p_p1;
	logic [63:0] ll_p2, lh_p2, hl_p2, hh_p2;
	logic [26:0] dist_p3;
	logic [75:0] q_full;
	logic [27:0] q_p4;

	always_comb begin
		if (w2z_s[N][AW-1]) begin
			ang_c = '0;
		end else if (w2z_s[N] > HALF_TURN) begin
			ang_c = HALF_TURN;
		end else begin
			ang_c = w2z_s[N];
		end
		ang_u = ang_c[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_s1 <= 1'b0;
			vp_s2 <= 1'b0;
			vp_s3 <= 1'b0;
			vp_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vp_s1 <= w2v_s[N];
			vp_s2 <= vp_s1;
			vp_s3 <= vp_s2;
			vp_s4 <= vp_s3;
			out_valid_q <= vp_s4;
		end
	end

	assign q_full = 76'(dist_p3) * 76'(DIV_RECIP);

	always_ff @(posedge clk) begin
		logic [119:0] sum;
		if (adv) begin
			p_p1 <= 56'(ang_u) * 56'(radius_q);
			ll_p2 <= 64'(p_p1[31:0]) * 64'(TWO_PI_LO);
			lh_p2 <= 64'(p_p1[31:0]) * 64'(TWO_PI_HI);
			hl_p2 <= 64'(p_p1[55:32]) * 64'(TWO_PI_LO);
			hh_p2 <= 64'(p_p1[55:32]) * 64'(TWO_PI_HI);
			sum = {hh_p2[55:0], 64'd0} + {24'd0, lh_p2, 32'd0}
				+ {24'd0, hl_p2, 32'd0} + {56'd0, ll_p2};
			dist_p3 <= sum[119:93];
			q_p4 <= q_full[DIV_SHIFT +: 28];
			weight_q <= (q_p4 > 28'(WEIGHT_MAX)) ? WEIGHT_MAX : q_p4[WEIGHT_W-1:0];
		end
	end

	// The rotation fold must leave the first latitude's start angle within a quarter turn.
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s[0] |-> (rz_s[0][0] <= QUARTER_TURN && rz_s[0][0] >= -QUARTER_TURN))
		else $error("rotation start angle outside a quarter turn");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (r_s3[0] < 6'd45 && r_s3[1] < 6'd45 && r_s3[2] < 6'd45))
		else $error("degree conversion remainder out of range");

	a_prerot: assert property (@(posedge clk) disable iff (!arst_n)
		w2v_s[0] |-> !w2x_s[0][TW-1])
		else $error("vectoring start has negative x");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vp_s4 && !adv) |=> (vp_s4 && $stable(q_p4)))
		else $error("pipeline moved during a stall");

endmodule
`default_nettype wire
